@@ rtl/core/mtc_pkg.sv @@
`timescale 1ns / 1ps
// ============================================================================
// mtc_pkg
// shared types, register map and request codes of the match timer counter
// ============================================================================
package mtc_pkg;

    localparam int COUNT_WIDTH_DEF    = 32;
    localparam int MATCH_CHANNELS_DEF = 4;

    localparam int DATA_W  = 32;
    localparam int ADDR_W  = 4;
    localparam int REQ_W   = 2;
    localparam int PWM_W   = 4;
    localparam int IN_TDATA_W  = 40;
    localparam int OUT_TDATA_W = 40;

    // per channel match control bits
    localparam int MCR_BITS = 3;
    localparam int MCR_INT  = 0;
    localparam int MCR_RST  = 1;
    localparam int MCR_STOP = 2;

    localparam logic [REQ_W-1:0] REQ_TICK  = 2'd0;
    localparam logic [REQ_W-1:0] REQ_READ  = 2'd1;
    localparam logic [REQ_W-1:0] REQ_WRITE = 2'd2;

    localparam logic [ADDR_W-1:0] ADDR_FLAGS   = 4'd0;
    localparam logic [ADDR_W-1:0] ADDR_CTRL    = 4'd1;
    localparam logic [ADDR_W-1:0] ADDR_COUNT   = 4'd2;
    localparam logic [ADDR_W-1:0] ADDR_PLIMIT  = 4'd3;
    localparam logic [ADDR_W-1:0] ADDR_PCOUNT  = 4'd4;
    localparam logic [ADDR_W-1:0] ADDR_MCR     = 4'd5;
    localparam logic [ADDR_W-1:0] ADDR_MATCH0  = 4'd6;
    localparam logic [ADDR_W-1:0] ADDR_MATCH1  = 4'd7;
    localparam logic [ADDR_W-1:0] ADDR_MATCH2  = 4'd8;
    localparam logic [ADDR_W-1:0] ADDR_MATCH3  = 4'd9;
    localparam logic [ADDR_W-1:0] ADDR_PWM_EN  = 4'd10;

    typedef struct packed {
        logic [REQ_W-1:0]  req_type;
        logic [ADDR_W-1:0] reg_addr;
        logic [DATA_W-1:0] write_data;
    } t_req;

    typedef struct packed {
        logic [DATA_W-1:0] read_data;
        logic              irq_line;
        logic [PWM_W-1:0]  pwm_pins;
    } t_rsp;

endpackage

@@ rtl/core/mtc_timer.sv @@
`timescale 1ns / 1ps
// ============================================================================
// mtc_timer
// timer state registers with tick, read and write handling
// ============================================================================
module mtc_timer
    import mtc_pkg::*;
#(
    parameter int COUNT_WIDTH    = COUNT_WIDTH_DEF,
    parameter int MATCH_CHANNELS = MATCH_CHANNELS_DEF
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_fire,
    input  t_req i_req,
    output t_rsp o_rsp
);

    localparam int CW = COUNT_WIDTH;
    localparam int MC = MATCH_CHANNELS;
    localparam int MCR_W = MCR_BITS * MC;

    logic [MC-1:0]    r_flags, n_flags;
    logic             r_enable, n_enable;
    logic [CW-1:0]    r_count, n_count;
    logic [CW-1:0]    r_plimit, n_plimit;
    logic [CW-1:0]    r_pcount, n_pcount;
    logic [MCR_W-1:0] r_mcr, n_mcr;
    logic [CW-1:0]    r_match [MC];
    logic [CW-1:0]    n_match [MC];
    logic [MC-1:0]    r_pwm_en, n_pwm_en;

    logic [CW-1:0]     w_inc;
    logic [MC-1:0]     w_rst_hit;
    logic [MC-1:0]     w_inc_eq;
    logic [MC-1:0]     w_zero_eq;
    logic              w_zero;
    logic [ADDR_W-1:0] w_chan_sel;
    logic [DATA_W-1:0] w_rd;
    logic [MC-1:0]     w_pins;

    assign w_inc      = r_count + 1'b1;
    assign w_chan_sel = i_req.reg_addr - ADDR_MATCH0;

    always_comb begin
        for (int ch = 0; ch < MC; ch++) begin
            w_rst_hit[ch] = r_mcr[MCR_BITS*ch + MCR_RST] && (r_count == r_match[ch]);
            w_inc_eq[ch]  = (w_inc == r_match[ch]);
            w_zero_eq[ch] = (r_match[ch] == '0);
        end
    end

    assign w_zero = |w_rst_hit;

    always_comb begin
        n_flags  = r_flags;
        n_enable = r_enable;
        n_count  = r_count;
        n_plimit = r_plimit;
        n_pcount = r_pcount;
        n_mcr    = r_mcr;
        n_match  = r_match;
        n_pwm_en = r_pwm_en;
        w_rd     = '0;
        if (i_fire) begin
            unique case (i_req.req_type)
                REQ_TICK: begin
                    if (r_enable) begin
                        if (r_pcount >= r_plimit) begin
                            n_pcount = '0;
                            n_count  = w_zero ? '0 : w_inc;
                            for (int ch = 0; ch < MC; ch++) begin
                                if (w_zero ? w_zero_eq[ch] : w_inc_eq[ch]) begin
                                    if (r_mcr[MCR_BITS*ch + MCR_INT]) begin
                                        n_flags[ch] = 1'b1;
                                    end
                                    if (r_mcr[MCR_BITS*ch + MCR_STOP]) begin
                                        n_enable = 1'b0;
                                    end
                                end
                            end
                        end else begin
                            n_pcount = r_pcount + 1'b1;
                        end
                    end
                end
                REQ_READ: begin
                    unique case (i_req.reg_addr) inside
                        ADDR_FLAGS:  w_rd = DATA_W'(r_flags);
                        ADDR_CTRL:   w_rd = DATA_W'(r_enable);
                        ADDR_COUNT:  w_rd = DATA_W'(r_count);
                        ADDR_PLIMIT: w_rd = DATA_W'(r_plimit);
                        ADDR_PCOUNT: w_rd = DATA_W'(r_pcount);
                        ADDR_MCR:    w_rd = DATA_W'(r_mcr);
                        ADDR_MATCH0, ADDR_MATCH1, ADDR_MATCH2, ADDR_MATCH3: begin
                            for (int ch = 0; ch < MC; ch++) begin
                                if (w_chan_sel == ADDR_W'(ch)) begin
                                    w_rd = DATA_W'(r_match[ch]);
                                end
                            end
                        end
                        ADDR_PWM_EN: w_rd = DATA_W'(r_pwm_en);
                        default:     w_rd = '0;
                    endcase
                end
                REQ_WRITE: begin
                    unique case (i_req.reg_addr) inside
                        ADDR_FLAGS:  n_flags  = r_flags & ~i_req.write_data[MC-1:0];
                        ADDR_CTRL:   n_enable = i_req.write_data[0];
                        ADDR_COUNT:  n_count  = i_req.write_data[CW-1:0];
                        ADDR_PLIMIT: n_plimit = i_req.write_data[CW-1:0];
                        ADDR_PCOUNT: n_pcount = i_req.write_data[CW-1:0];
                        ADDR_MCR:    n_mcr    = i_req.write_data[MCR_W-1:0];
                        ADDR_MATCH0, ADDR_MATCH1, ADDR_MATCH2, ADDR_MATCH3: begin
                            for (int ch = 0; ch < MC; ch++) begin
                                if (w_chan_sel == ADDR_W'(ch)) begin
                                    n_match[ch] = i_req.write_data[CW-1:0];
                                end
                            end
                        end
                        ADDR_PWM_EN: n_pwm_en = i_req.write_data[MC-1:0];
                        default:     ;
                    endcase
                end
                default: ;
            endcase
        end
    end

    // pwm pins from the state after this word
    always_comb begin
        for (int ch = 0; ch < MC; ch++) begin
            w_pins[ch] = n_pwm_en[ch] && (n_count < n_match[ch]);
        end
    end

    assign o_rsp.read_data = w_rd;
    assign o_rsp.irq_line  = |n_flags;
    assign o_rsp.pwm_pins  = PWM_W'(w_pins);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_flags  <= '0;
            r_enable <= 1'b0;
            r_count  <= '0;
            r_plimit <= '0;
            r_pcount <= '0;
            r_mcr    <= '0;
            r_pwm_en <= '0;
            for (int ch = 0; ch < MC; ch++) begin
                r_match[ch] <= '0;
            end
        end else begin
            r_flags  <= n_flags;
            r_enable <= n_enable;
            r_count  <= n_count;
            r_plimit <= n_plimit;
            r_pcount <= n_pcount;
            r_mcr    <= n_mcr;
            r_pwm_en <= n_pwm_en;
            r_match  <= n_match;
        end
    end

endmodule

@@ rtl/core/match_timer_counter.sv @@
`timescale 1ns / 1ps
// ============================================================================
// match_timer_counter
// prescaled timer/counter with match registers, driven by a request stream
// ----------------------------------------------------------------------------
// The slave channel carries one request word per handshake: tuser holds the
// request kind (tick, register read, register write), tdata the register
// address and write data. The master channel returns exactly one result word
// per request: read data (zero unless a read), the interrupt line and the
// pwm pins, all as they stand after the request.
// A request is captured in an input register, worked against the timer
// state and placed in the result register, from which its result is
// offered. One request per cycle is taken in steady state while the
// receiver does not stall; the combinational state update sets that rate.
// When the receiver stalls, the result register holds its word and one more
// request may wait in the input register; tready then drops until the
// result is taken.
// Reset clears all timer registers, flags and the valid bits of both pipeline stages.
// ============================================================================
module match_timer_counter
    import mtc_pkg::*;
#(
    parameter int COUNT_WIDTH    = COUNT_WIDTH_DEF,
    parameter int MATCH_CHANNELS = MATCH_CHANNELS_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_s_axis_tvalid,
    output logic                   o_s_axis_tready,
    // [3:0] reg_addr, [35:4] write_data, [39:36] zero
    input  logic [IN_TDATA_W-1:0]  i_s_axis_tdata,
    // [1:0] req_type
    input  logic [REQ_W-1:0]       i_s_axis_tuser,
    output logic                   o_m_axis_tvalid,
    input  logic                   i_m_axis_tready,
    // [31:0] read_data, [32] irq_line, [36:33] pwm_pins, [39:37] zero
    output logic [OUT_TDATA_W-1:0] o_m_axis_tdata
);

    logic r_in_valid;
    t_req r_in;
    logic r_out_valid;
    t_rsp r_out;
    logic w_fire;
    t_rsp w_rsp;

    assign w_fire          = r_in_valid && (!r_out_valid || i_m_axis_tready);
    assign o_s_axis_tready = !r_in_valid || w_fire;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_s_axis_tready) begin
            r_in_valid <= i_s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_s_axis_tready && i_s_axis_tvalid) begin
            r_in.req_type   <= i_s_axis_tuser;
            r_in.reg_addr   <= i_s_axis_tdata[ADDR_W-1:0];
            r_in.write_data <= i_s_axis_tdata[ADDR_W +: DATA_W];
        end
    end

    mtc_timer #(
        .COUNT_WIDTH    (COUNT_WIDTH),
        .MATCH_CHANNELS (MATCH_CHANNELS)
    ) u_timer (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_fire  (w_fire),
        .i_req   (r_in),
        .o_rsp   (w_rsp)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_fire) begin
            r_out_valid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_fire) begin
            r_out <= w_rsp;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {3'b000, r_out.pwm_pins, r_out.irq_line, r_out.read_data};

    // full input stage behind a stalled result cannot take a word
    a_stall_blocks_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && r_out_valid && !i_m_axis_tready) |-> !o_s_axis_tready)
        else $error("input accepted while both stages are stalled");

    a_fire_gives_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_fire |=> o_m_axis_tvalid)
        else $error("processed word produced no result");

    a_read_data_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_fire && (r_in.req_type != REQ_READ)) |=> (r_out.read_data == '0))
        else $error("read data nonzero for a non-read request");

endmodule
